@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the deframer back end.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed: invariant violated");

// Checks that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication violated");

// Checks that a condition implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication violated");

`endif

@@ rtl/core/tsd_pkg.sv @@
// Shared types and constants of the telemetry sentence deframer.
package tsd_pkg;

	// Default depth of the command queue between front and back.
	localparam int QueueDepth = 4;

	// The star character that forms the terminator.
	localparam logic [7:0] StarChar = 8'h2A;

	// Reset value of the prefix register, "$AR:".
	localparam logic [31:0] PrefixReset = 32'h2441523A;

	// Commands that the front hands to the back.
	typedef enum logic [1:0] {
		OP_PASS,
		OP_STAR_PAIR,
		OP_END
	} op_t;

	// One queued command: a body byte, a star pair, or a frame end with its XOR and check result.
	typedef struct packed {
		op_t        op;
		logic [7:0] data;
		logic       ok;
	} cmd_t;

endpackage

@@ rtl/core/tsd_front.sv @@
// Front end: prefix hunt, star handling, running XOR and checksum parse.
module tsd_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              q_full,
	input  logic [7:0]        rx_byte,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [31:0]       cfg_data,
	output logic              q_push,
	output tsd_pkg::cmd_t     q_cmd
);

	typedef enum logic [2:0] {
		PH_HUNT,
		PH_BODY,
		PH_STAR,
		PH_HEX1,
		PH_HEX2
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [1:0]  idx_q, idx_d;
	logic [7:0]  xor_q, xor_d;
	logic [3:0]  hi_q, hi_d;
	logic        bad_q, bad_d;
	logic [31:0] prefix_q;
	logic        accept;
	logic [7:0]  pb_cur;
	logic [4:0]  hex_v;
	logic [7:0]  rx_sum;
	logic        emit;
	tsd_pkg::cmd_t cmd_d;

	// Returns the digit value, or 16 when the byte is not a hex digit.
	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'd16;
		if (c >= 8'h30 && c <= 8'h39) begin
			v = 5'(c - 8'h30);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			v = 5'(c - 8'h37);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			v = 5'(c - 8'h57);
		end
		return v;
	endfunction

	assign cfg_ready = 1'b1;
	assign accept    = push && !q_full;

	// Expected prefix byte at the current match position.
	assign pb_cur = prefix_q[{~idx_q, 3'b000} +: 8];
	assign hex_v  = hex_value(rx_byte);
	assign rx_sum = {hi_q, hex_v[3:0]};

	// Next state and the command caused by the incoming byte.
	always_comb begin
		phase_d = phase_q;
		idx_d   = idx_q;
		xor_d   = xor_q;
		hi_d    = hi_q;
		bad_d   = bad_q;
		emit    = 1'b0;
		cmd_d   = '{op: tsd_pkg::OP_PASS, data: rx_byte, ok: 1'b0};
		unique case (phase_q)
			PH_BODY: begin
				if (rx_byte == tsd_pkg::StarChar) begin
					phase_d = PH_STAR;
				end else begin
					xor_d = xor_q ^ rx_byte;
					emit  = 1'b1;
				end
			end
			PH_STAR: begin
				if (rx_byte == tsd_pkg::StarChar) begin
					phase_d = PH_HEX1;
				end else begin
					xor_d     = xor_q ^ tsd_pkg::StarChar ^ rx_byte;
					emit      = 1'b1;
					cmd_d.op  = tsd_pkg::OP_STAR_PAIR;
					phase_d   = PH_BODY;
				end
			end
			PH_HEX1: begin
				bad_d   = hex_v[4];
				hi_d    = hex_v[3:0];
				phase_d = PH_HEX2;
			end
			PH_HEX2: begin
				emit       = 1'b1;
				cmd_d.op   = tsd_pkg::OP_END;
				cmd_d.data = xor_q;
				cmd_d.ok   = !(bad_q || hex_v[4]) && (rx_sum == xor_q);
				phase_d    = PH_HUNT;
				idx_d      = 2'd0;
				bad_d      = 1'b0;
				hi_d       = 4'd0;
			end
			default: begin
				phase_d = PH_HUNT;
				if (rx_byte == pb_cur) begin
					if (idx_q == 2'd3) begin
						// The XOR is seeded with every prefix byte after the first.
						xor_d   = prefix_q[23:16] ^ prefix_q[15:8] ^ prefix_q[7:0];
						idx_d   = 2'd0;
						phase_d = PH_BODY;
					end else begin
						idx_d = idx_q + 2'd1;
					end
				end else begin
					idx_d = (rx_byte == prefix_q[31:24]) ? 2'd1 : 2'd0;
				end
			end
		endcase
	end

	assign q_push = accept && emit;
	assign q_cmd  = cmd_d;

	// Parser state and the prefix register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HUNT;
			idx_q    <= 2'd0;
			xor_q    <= 8'd0;
			hi_q     <= 4'd0;
			bad_q    <= 1'b0;
			prefix_q <= tsd_pkg::PrefixReset;
		end else begin
			if (accept) begin
				phase_q <= phase_d;
				idx_q   <= idx_d;
				xor_q   <= xor_d;
				hi_q    <= hi_d;
				bad_q   <= bad_d;
			end
			if (cfg_valid && cfg_ready) begin
				prefix_q <= cfg_data;
			end
		end
	end

endmodule

@@ rtl/core/tsd_queue.sv @@
// Short command queue between the front and back ends.
module tsd_queue #(
	parameter int DEPTH = tsd_pkg::QueueDepth
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  tsd_pkg::cmd_t wr_cmd,
	output logic          full,
	input  logic          rd_en,
	output tsd_pkg::cmd_t rd_cmd,
	output logic          empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	tsd_pkg::cmd_t mem_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full   = (count_q == CW'(DEPTH));
	assign empty  = (count_q == '0);
	assign rd_cmd = mem_q[rd_ptr_q];

	// Storage write.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/tsd_back.sv @@
// Back end: expands queued commands into result items in an output register.
`include "assert_macros.svh"

module tsd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_empty,
	input  tsd_pkg::cmd_t q_cmd,
	output logic          q_pop,
	input  logic          pop,
	output logic          empty,
	output logic          kind,
	output logic [7:0]    data_byte,
	output logic          checksum_ok,
	output logic          last_of_step
);

	logic       out_valid_q;
	logic       kind_q;
	logic [7:0] data_q;
	logic       ok_q;
	logic       last_q;
	logic       second_q;
	logic [7:0] data2_q;
	logic       can_load;

	assign empty        = !out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign checksum_ok  = ok_q;
	assign last_of_step = last_q;

	// The output register takes a new result when free or being transferred.
	assign can_load = !out_valid_q || pop;
	assign q_pop    = can_load && !second_q && !q_empty;

	// Valid flag and the pending second half of a star pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else if (can_load) begin
			if (second_q) begin
				out_valid_q <= 1'b1;
				second_q    <= 1'b0;
			end else if (!q_empty) begin
				out_valid_q <= 1'b1;
				second_q    <= (q_cmd.op == tsd_pkg::OP_STAR_PAIR);
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload.
	always_ff @(posedge clk) begin
		if (can_load) begin
			if (second_q) begin
				kind_q <= 1'b0;
				data_q <= data2_q;
				ok_q   <= 1'b0;
				last_q <= 1'b1;
			end else if (!q_empty) begin
				unique case (q_cmd.op)
					tsd_pkg::OP_STAR_PAIR: begin
						kind_q  <= 1'b0;
						data_q  <= tsd_pkg::StarChar;
						ok_q    <= 1'b0;
						last_q  <= 1'b0;
						data2_q <= q_cmd.data;
					end
					tsd_pkg::OP_END: begin
						kind_q <= 1'b1;
						data_q <= q_cmd.data;
						ok_q   <= q_cmd.ok;
						last_q <= 1'b1;
					end
					default: begin
						kind_q <= 1'b0;
						data_q <= q_cmd.data;
						ok_q   <= 1'b0;
						last_q <= 1'b1;
					end
				endcase
			end
		end
	end

	// While the second byte is pending, the released star is on the outputs.
	`ASSERT_IMPLIES(a_star_shown, clk, arst_n, second_q, out_valid_q && !last_q && !kind_q && data_q == tsd_pkg::StarChar)
	// A frame end is always the last result of its byte.
	`ASSERT_IMPLIES(a_end_last, clk, arst_n, out_valid_q && kind_q, last_q && !second_q)
	// The pending byte either waits or appears as the closing result.
	`ASSERT_NEXT(a_pair_closes, clk, arst_n, second_q, second_q || (out_valid_q && last_q && !kind_q))

endmodule

@@ rtl/core/telemetry_sentence_deframer.sv @@
// Top level of the telemetry sentence deframer.
// A result passes through the command queue and then the output register.
// Throughput: one byte per cycle while not full; a byte that releases a held star yields
// two results, and the single result port drains one result per cycle while pop is high.
// The command queue of QUEUE_DEPTH entries absorbs such bursts and output stalls.
// Reset (arst_n low, asynchronous) empties the queue and output and restores the prefix.
module telemetry_sentence_deframer #(
	parameter int QUEUE_DEPTH = tsd_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	input  logic        pop,
	output logic        empty,
	output logic        kind,
	output logic [7:0]  data_byte,
	output logic        checksum_ok,
	output logic        last_of_step,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data
);

	logic          q_push;
	logic          q_pop;
	logic          q_full;
	logic          q_empty;
	tsd_pkg::cmd_t q_wr_cmd;
	tsd_pkg::cmd_t q_rd_cmd;

	assign full = q_full;

	// Parser front end.
	tsd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.q_full    (q_full),
		.rx_byte   (rx_byte),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.q_push    (q_push),
		.q_cmd     (q_wr_cmd)
	);

	// Command queue.
	tsd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_cmd (q_wr_cmd),
		.full   (q_full),
		.rd_en  (q_pop),
		.rd_cmd (q_rd_cmd),
		.empty  (q_empty)
	);

	// Result back end.
	tsd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (q_empty),
		.q_cmd        (q_rd_cmd),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.data_byte    (data_byte),
		.checksum_ok  (checksum_ok),
		.last_of_step (last_of_step)
	);

endmodule

@@ sim/tb.sv @@
// Self-checking testbench for the telemetry sentence deframer.
`timescale 1ns / 1ps

module tb;

	// Result kinds on the kind port.
	localparam logic KindBody = 1'b0;
	localparam logic KindEnd  = 1'b1;

	// Cycles without any transfer before the run is declared hung.
	localparam int HangLimit = 2000;
	// Cycles to let the pipeline settle once no result is pending.
	localparam int SettleCycles = 6;
	// Minimum input bytes per random phase.
	localparam int PhaseBytes = 100;

	typedef enum logic [2:0] {
		SEEK,
		BODY,
		HELD_STAR,
		CK_HI,
		CK_LO
	} sync_state_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic       ok;
		logic       last;
	} frame_out_t;

	typedef struct packed {
		logic [7:0] rx;
		logic       typed;
		frame_out_t want;
	} script_row_t;

	localparam frame_out_t NotTyped = '0;
	localparam int ScriptLen = 22;

	// Two frames with the reset prefix: a false start, the byte extremes,
	// a held star released by a plain byte, a good checksum, then an empty
	// body with a checksum digit that is not hex.
	localparam script_row_t Script [ScriptLen] = '{
		'{8'h24, 1'b0, NotTyped},
		'{8'h41, 1'b0, NotTyped},
		'{8'h24, 1'b0, NotTyped},
		'{8'h41, 1'b0, NotTyped},
		'{8'h52, 1'b0, NotTyped},
		'{8'h3A, 1'b0, NotTyped},
		'{8'h00, 1'b1, '{KindBody, 8'h00, 1'b0, 1'b1}},
		'{8'hFF, 1'b1, '{KindBody, 8'hFF, 1'b0, 1'b1}},
		'{8'h2A, 1'b0, NotTyped},
		'{8'h41, 1'b0, NotTyped},
		'{8'h2A, 1'b0, NotTyped},
		'{8'h2A, 1'b0, NotTyped},
		'{8'h62, 1'b0, NotTyped},
		'{8'h44, 1'b0, NotTyped},
		'{8'h24, 1'b0, NotTyped},
		'{8'h41, 1'b0, NotTyped},
		'{8'h52, 1'b0, NotTyped},
		'{8'h3A, 1'b0, NotTyped},
		'{8'h2A, 1'b0, NotTyped},
		'{8'h2A, 1'b0, NotTyped},
		'{8'h67, 1'b0, NotTyped},
		'{8'h30, 1'b1, '{KindEnd, 8'h29, 1'b0, 1'b1}}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  rx_byte;
	logic        pop;
	logic        empty;
	logic        kind;
	logic [7:0]  data_byte;
	logic        checksum_ok;
	logic        last_of_step;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [31:0] cfg_data;

	// Predictor state.
	logic [31:0] rx_prefix;
	sync_state_t sync_state;
	logic [1:0]  match_count;
	logic [7:0]  sentence_xor;
	logic [3:0]  ck_high;
	logic        ck_bad;

	frame_out_t pending_out [$];
	frame_out_t oldest_out;
	int         fault_count = 0;
	int         quiet_cycles = 0;
	int         stall_left = 0;
	bit         calm = 1'b0;

	always #5 clk = ~clk;

	telemetry_sentence_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.rx_byte(rx_byte),
		.pop(pop),
		.empty(empty),
		.kind(kind),
		.data_byte(data_byte),
		.checksum_ok(checksum_ok),
		.last_of_step(last_of_step),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	function automatic logic [7:0] prefix_octet(input logic [31:0] p, input int i);
		return p[31 - 8 * i -: 8];
	endfunction

	// Value of a checksum character, or 16 when it is not a hex digit.
	function automatic logic [4:0] hex_digit_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return 5'(c - 8'h30);
		if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
		if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
		return 5'd16;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit upper);
		if (n < 4'd10) return 8'h30 + 8'(n);
		return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	// Advances the predicted deframer by one byte; queues its results if asked.
	task automatic deframe_byte(input logic [7:0] c, input bit keep);
		frame_out_t r0;
		frame_out_t r1;
		int n;
		logic [4:0] v;
		logic [7:0] got_ck;
		n = 0;
		r0 = '0;
		r1 = '0;
		case (sync_state)
			BODY: begin
				if (c == tsd_pkg::StarChar) begin
					sync_state = HELD_STAR;
				end else begin
					sentence_xor ^= c;
					r0 = '{KindBody, c, 1'b0, 1'b0};
					n = 1;
				end
			end
			HELD_STAR: begin
				if (c == tsd_pkg::StarChar) begin
					sync_state = CK_HI;
				end else begin
					// The held star goes out first, then the new byte.
					sentence_xor ^= tsd_pkg::StarChar ^ c;
					r0 = '{KindBody, tsd_pkg::StarChar, 1'b0, 1'b0};
					r1 = '{KindBody, c, 1'b0, 1'b0};
					n = 2;
					sync_state = BODY;
				end
			end
			CK_HI: begin
				v = hex_digit_value(c);
				ck_bad = v[4];
				ck_high = v[3:0];
				sync_state = CK_LO;
			end
			CK_LO: begin
				v = hex_digit_value(c);
				got_ck = {ck_high, v[3:0]};
				r0 = '{KindEnd, sentence_xor,
					!(ck_bad || v[4]) && got_ck == sentence_xor, 1'b0};
				n = 1;
				sync_state = SEEK;
				match_count = 2'd0;
				ck_bad = 1'b0;
				ck_high = 4'd0;
			end
			default: begin
				if (c == prefix_octet(rx_prefix, match_count)) begin
					if (match_count == 2'd3) begin
						sentence_xor = prefix_octet(rx_prefix, 1) ^
							prefix_octet(rx_prefix, 2) ^ prefix_octet(rx_prefix, 3);
						match_count = 2'd0;
						sync_state = BODY;
					end else begin
						match_count = match_count + 2'd1;
					end
				end else begin
					// A broken match may still start over on this byte.
					match_count = (c == prefix_octet(rx_prefix, 0)) ? 2'd1 : 2'd0;
				end
			end
		endcase
		if (keep) begin
			if (n == 1) begin
				r0.last = 1'b1;
				pending_out.push_back(r0);
			end else if (n == 2) begin
				r1.last = 1'b1;
				pending_out.push_back(r0);
				pending_out.push_back(r1);
			end
		end
	endtask

	// Offers one byte, with an occasional idle burst first, and waits for its transfer.
	task automatic send_byte(input logic [7:0] b, input bit predicted);
		int gap;
		if (!calm && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 18);
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		push <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (full);
		deframe_byte(b, predicted);
	endtask

	// Drops push and waits until the block has delivered everything.
	task automatic quiesce();
		@(negedge clk);
		push <= 1'b0;
		while (pending_out.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_prefix(input logic [31:0] p);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= p;
		do @(posedge clk); while (!cfg_ready);
		rx_prefix = p;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		b = 8'($urandom_range(0, 255));
		return (b == tsd_pkg::StarChar) ? 8'h2B : b;
	endfunction

	// One sentence: some noise, the prefix (now and then broken), a body with
	// stray stars, the terminator and a checksum that is mostly right.
	task automatic send_sentence(inout int sent);
		int noise;
		int len;
		int pick;
		logic [7:0] b;
		logic [7:0] ck;
		logic [4:0] dv;
		noise = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (noise) begin
			send_byte(8'($urandom_range(0, 255)), 1'b1);
			sent++;
		end
		pick = $urandom_range(0, 11);
		for (int i = 0; i < 4; i++) begin
			b = prefix_octet(rx_prefix, i);
			if (pick == i) b = 8'($urandom_range(0, 255));
			send_byte(b, 1'b1);
			sent++;
		end
		len = $urandom_range(0, 10);
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 5) == 0) begin
				send_byte(tsd_pkg::StarChar, 1'b1);
				sent++;
			end
			send_byte(plain_byte(), 1'b1);
			sent++;
		end
		send_byte(tsd_pkg::StarChar, 1'b1);
		send_byte(tsd_pkg::StarChar, 1'b1);
		sent += 2;
		ck = sentence_xor;
		pick = $urandom_range(0, 9);
		if (pick == 0) ck ^= 8'($urandom_range(1, 255));
		for (int i = 0; i < 2; i++) begin
			b = hex_char(i == 0 ? ck[7:4] : ck[3:0], 1'($urandom_range(0, 1)));
			if (pick == 1 && $urandom_range(0, 1) == i) begin
				do begin
					b = 8'($urandom_range(0, 255));
					dv = hex_digit_value(b);
				end while (!dv[4]);
			end
			send_byte(b, 1'b1);
			sent++;
		end
	endtask

	task automatic run_sentences();
		int sent;
		sent = 0;
		while (sent < PhaseBytes) send_sentence(sent);
	endtask

	// Result side: pop held high, with random stall bursts.
	always @(negedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			pop <= 1'b0;
		end else if (!calm && $urandom_range(0, 15) == 0) begin
			stall_left <= $urandom_range(0, 17);
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	// Compare each result transfer with the oldest prediction.
	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (pending_out.size() == 0) begin
				$display("%0t: unexpected result, expected none, got kind %0d data %02h ok %0d last %0d",
					$time, kind, data_byte, checksum_ok, last_of_step);
				fault_count++;
			end else begin
				oldest_out = pending_out.pop_front();
				if (kind !== oldest_out.kind) begin
					$display("%0t: kind expected %0d got %0d", $time, oldest_out.kind, kind);
					fault_count++;
				end
				if (data_byte !== oldest_out.data) begin
					$display("%0t: data_byte expected %02h got %02h",
						$time, oldest_out.data, data_byte);
					fault_count++;
				end
				if (checksum_ok !== oldest_out.ok) begin
					$display("%0t: checksum_ok expected %0d got %0d",
						$time, oldest_out.ok, checksum_ok);
					fault_count++;
				end
				if (last_of_step !== oldest_out.last) begin
					$display("%0t: last_of_step expected %0d got %0d",
						$time, oldest_out.last, last_of_step);
					fault_count++;
				end
			end
		end
	end

	// Hang detection: count cycles in which no transfer happens.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= HangLimit) begin
				$display("%0t: no transfer for %0d cycles", $time, HangLimit);
				$display("tb: errors");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = 8'h00;
		pop = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 32'h0;
		rx_prefix = tsd_pkg::PrefixReset;
		sync_state = SEEK;
		match_count = 2'd0;
		sentence_xor = 8'h00;
		ck_high = 4'd0;
		ck_bad = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows: typed expectations replace the predicted ones.
		for (int i = 0; i < ScriptLen; i++) begin
			send_byte(Script[i].rx, !Script[i].typed);
			if (Script[i].typed) pending_out.push_back(Script[i].want);
		end
		run_sentences();

		// Random sentences under several prefixes, the extremes among them.
		quiesce();
		set_prefix(32'h2447443A);
		run_sentences();
		quiesce();
		set_prefix(32'h00000000);
		run_sentences();
		quiesce();
		set_prefix(32'hFFFFFFFF);
		run_sentences();
		quiesce();
		set_prefix($urandom());
		run_sentences();
		quiesce();
		set_prefix($urandom());
		run_sentences();

		// Last stretch at full rate on both sides.
		quiesce();
		calm = 1'b1;
		set_prefix(tsd_pkg::PrefixReset);
		run_sentences();
		quiesce();

		if (fault_count == 0 && pending_out.size() == 0) begin
			$display("tb: clean");
		end else begin
			$display("tb: errors");
		end
		$finish;
	end

endmodule
